@@ rtl/de_esser_biquad_envelope_gain_top_defines.svh @@
`ifndef DE_ESSER_BIQUAD_ENVELOPE_GAIN_TOP_DEFINES_SVH
`define DE_ESSER_BIQUAD_ENVELOPE_GAIN_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define DEESS_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("de-esser check failed");

// Next-cycle implication.
`define DEESS_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("de-esser check failed");

`endif

@@ rtl/deess_pkg.sv @@
`timescale 1ns / 1ps

package deess_pkg;

   localparam int COEF_W     = 24;
   localparam int THR_W      = 23;
   localparam int COEF_FRAC  = 22;
   localparam int ENV_FRAC   = 24;
   localparam int Y_W        = 32;

   // shared multiplier: coefficient side x data side
   localparam int MUL_A_W    = 26;
   localparam int MUL_B_W    = 33;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = 60;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_BAND_B0       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_A1       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_A2       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_COEF   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_COEF  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_LIN = 3'd5;

   localparam logic signed [COEF_W-1:0] RST_BAND_B0       = 24'sd1398101;
   localparam logic signed [COEF_W-1:0] RST_BAND_A1       = -24'sd3954428;
   localparam logic signed [COEF_W-1:0] RST_BAND_A2       = 24'sd1398101;
   localparam logic [COEF_W-1:0]        RST_ATTACK_COEF   = 24'd16431302;
   localparam logic [COEF_W-1:0]        RST_RELEASE_COEF  = 24'd16770227;
   localparam logic [THR_W-1:0]         RST_THRESHOLD_LIN = 23'd1056062;

   localparam logic [COEF_W:0] ENV_ONE = 25'h1000000;

   localparam logic signed [ACC_W-1:0] BQ_HALF  = ACC_W'(1) << (COEF_FRAC - 1);
   localparam logic signed [ACC_W-1:0] ENV_HALF = ACC_W'(1) << (ENV_FRAC - 1);
   localparam logic signed [ACC_W-1:0] Y_HI = {{(ACC_W-Y_W+1){1'b0}}, {(Y_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] Y_LO = {{(ACC_W-Y_W+1){1'b1}}, {(Y_W-1){1'b0}}};

endpackage

@@ rtl/deess_req_if.sv @@
`timescale 1ns / 1ps

interface deess_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          block_last;

   modport source (output valid, output sample_in, output block_last, input ready);
   modport sink   (input valid, input sample_in, input block_last, output ready);
endinterface

@@ rtl/deess_rsp_if.sv @@
`timescale 1ns / 1ps

interface deess_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          reducing;
   logic                          block_last_out;

   modport source (output valid, output sample_out, output reducing, output block_last_out,
                   input ready);
   modport sink   (input valid, input sample_out, input reducing, input block_last_out,
                   output ready);
endinterface

@@ rtl/de_esser_biquad_envelope_gain_top.sv @@
// De-esser: band-pass sidechain, attack/release envelope, threshold/level gain.
// Each accepted transaction runs the biquad, envelope, level and gain steps; when gain is
// reduced, the sample is also scaled and divided (restoring divider, 1 bit/cycle).
// One transaction at a time, a new one accepted only in idle; the time per sample is set by the
// single shared 26x33 multiplier and the serial divider.
// Synchronous active-high reset clears filter and envelope state and loads register defaults.
`timescale 1ns / 1ps
`include "de_esser_biquad_envelope_gain_top_defines.svh"

module de_esser_biquad_envelope_gain_top #(
   parameter int SAMPLE_BITS = 24,
   parameter int EPSILON_LSB = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   deess_req_if.sink                       req_ch,
   deess_rsp_if.source                     rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [deess_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [deess_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [deess_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import deess_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int LW = SB + 1;
   localparam int RW = SB + 1;
   localparam int TW = RW + 1;
   localparam int NW = SB + THR_W;
   localparam int CW = $clog2(SB);
   localparam int CMP_W = 33;
   localparam logic [32:0] DET_MAX = (33'd1 << SAMPLE_BITS) - 33'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BIQUAD,
      ST_ROUND,
      ST_ENV,
      ST_LEVEL,
      ST_GAIN,
      ST_SCALE,
      ST_DIV,
      ST_DONE
   } state_type;

   // ---------------- configuration registers ----------------
   logic signed [COEF_W-1:0] band_b0_ff, band_a1_ff, band_a2_ff;
   logic [COEF_W-1:0]        attack_ff, release_ff;
   logic [THR_W-1:0]         thr_ff;
   logic                     csr_wr;
   logic [CSR_IDX_W-1:0]     csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_b0_ff <= RST_BAND_B0;
         band_a1_ff <= RST_BAND_A1;
         band_a2_ff <= RST_BAND_A2;
         attack_ff  <= RST_ATTACK_COEF;
         release_ff <= RST_RELEASE_COEF;
         thr_ff     <= RST_THRESHOLD_LIN;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_BAND_B0:       band_b0_ff <= pwdata[COEF_W-1:0];
            CSR_BAND_A1:       band_a1_ff <= pwdata[COEF_W-1:0];
            CSR_BAND_A2:       band_a2_ff <= pwdata[COEF_W-1:0];
            CSR_ATTACK_COEF:   attack_ff  <= pwdata[COEF_W-1:0];
            CSR_RELEASE_COEF:  release_ff <= pwdata[COEF_W-1:0];
            CSR_THRESHOLD_LIN: thr_ff     <= pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_BAND_B0:       prdata = CSR_DATA_W'(unsigned'(band_b0_ff));
         CSR_BAND_A1:       prdata = CSR_DATA_W'(unsigned'(band_a1_ff));
         CSR_BAND_A2:       prdata = CSR_DATA_W'(unsigned'(band_a2_ff));
         CSR_ATTACK_COEF:   prdata = CSR_DATA_W'(attack_ff);
         CSR_RELEASE_COEF:  prdata = CSR_DATA_W'(release_ff);
         CSR_THRESHOLD_LIN: prdata = CSR_DATA_W'(thr_ff);
         default:           prdata = '0;
      endcase
   end

   // ---------------- datapath registers ----------------
   state_type                state_ff, state_in;
   logic [CW-1:0]            step_ff, step_in;
   logic signed [SB-1:0]     x_ff, x_in;
   logic                     last_ff, last_in;
   logic signed [SB-1:0]     x1_ff, x1_in, x2_ff, x2_in;
   logic signed [Y_W-1:0]    y1_ff, y1_in, y2_ff, y2_in;
   logic [SB-1:0]            env_ff, env_in;
   logic [SB-1:0]            det_ff, det_in;
   logic [COEF_W-1:0]        coef_ff, coef_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [LW-1:0]            level_ff, level_in;
   logic                     red_ff, red_in;
   logic [RW-1:0]            rem_ff, rem_in;
   logic [SB-1:0]            quo_ff, quo_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]     rsp_sample_ff, rsp_sample_in;
   logic                     rsp_red_ff, rsp_red_in;
   logic                     rsp_last_ff, rsp_last_in;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic [COEF_W:0]           coef_inv;
   logic [SB-1:0]             mag;

   assign coef_inv = ENV_ONE - {1'b0, coef_ff};
   assign mag      = x_ff[SB-1] ? SB'(-x_ff) : x_ff;

   always_comb begin
      case (state_ff)
         ST_BIQUAD: begin
            case (step_ff)
               CW'(0): begin
                  mul_a = MUL_A_W'(band_b0_ff);
                  mul_b = MUL_B_W'(x_ff);
               end
               CW'(1): begin
                  mul_a = MUL_A_W'(band_b0_ff);
                  mul_b = MUL_B_W'(x2_ff);
               end
               CW'(2): begin
                  mul_a = MUL_A_W'(band_a1_ff);
                  mul_b = MUL_B_W'(y1_ff);
               end
               default: begin
                  mul_a = MUL_A_W'(band_a2_ff);
                  mul_b = MUL_B_W'(y2_ff);
               end
            endcase
         end
         ST_ENV: begin
            if (step_ff == CW'(0)) begin
               mul_a = MUL_A_W'(coef_ff);
               mul_b = MUL_B_W'(env_ff);
            end else begin
               mul_a = MUL_A_W'(coef_inv);
               mul_b = MUL_B_W'(det_ff);
            end
         end
         default: begin
            mul_a = MUL_A_W'(thr_ff);
            mul_b = MUL_B_W'(mag);
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // accumulator, round/saturate, detector
   logic signed [ACC_W-1:0] acc_add, acc_sub, y_wide;
   logic signed [Y_W-1:0]   y_sat;
   logic [Y_W-1:0]          y_abs;
   logic [SB-1:0]           det_new;

   assign acc_add = acc_ff + ACC_W'(prod_ff);
   assign acc_sub = acc_ff - ACC_W'(prod_ff);
   assign y_wide  = acc_ff >>> COEF_FRAC;

   always_comb begin
      if (y_wide > Y_HI)
         y_sat = {1'b0, {(Y_W-1){1'b1}}};
      else if (y_wide < Y_LO)
         y_sat = {1'b1, {(Y_W-1){1'b0}}};
      else
         y_sat = y_wide[Y_W-1:0];
      y_abs   = y_sat[Y_W-1] ? Y_W'(-y_sat) : y_sat;
      det_new = ({1'b0, y_abs} > DET_MAX) ? '1 : SB'(y_abs);
   end

   // restoring divider step
   logic [TW-1:0] div_t, div_diff;
   logic          div_ge;

   assign div_t    = {rem_ff, quo_ff[SB-1]};
   assign div_ge   = div_t >= TW'(level_ff);
   assign div_diff = div_t - TW'(level_ff);

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      x_in          = x_ff;
      last_in       = last_ff;
      x1_in         = x1_ff;
      x2_in         = x2_ff;
      y1_in         = y1_ff;
      y2_in         = y2_ff;
      env_in        = env_ff;
      det_in        = det_ff;
      coef_in       = coef_ff;
      acc_in        = acc_ff;
      level_in      = level_ff;
      red_in        = red_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_red_in    = rsp_red_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               x_in     = req_ch.sample_in;
               last_in  = req_ch.block_last;
               acc_in   = BQ_HALF;
               step_in  = '0;
               state_in = ST_BIQUAD;
            end
         end
         ST_BIQUAD: begin
            // product of step n lands in acc at step n+1; all but b0*x subtract
            if (step_ff == CW'(1))
               acc_in = acc_add;
            else if (step_ff != CW'(0))
               acc_in = acc_sub;
            if (step_ff == CW'(4)) begin
               step_in  = '0;
               state_in = ST_ROUND;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         ST_ROUND: begin
            x2_in    = x1_ff;
            x1_in    = x_ff;
            y2_in    = y1_ff;
            y1_in    = y_sat;
            det_in   = det_new;
            coef_in  = (det_new > env_ff) ? attack_ff : release_ff;
            acc_in   = ENV_HALF;
            step_in  = '0;
            state_in = ST_ENV;
         end
         ST_ENV: begin
            if (step_ff != CW'(0))
               acc_in = acc_add;
            if (step_ff == CW'(2)) begin
               step_in  = '0;
               state_in = ST_LEVEL;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         ST_LEVEL: begin
            env_in   = acc_ff[ENV_FRAC +: SB];
            level_in = LW'(acc_ff[ENV_FRAC +: SB]) + LW'(EPSILON_LSB);
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            red_in   = CMP_W'(level_ff) > CMP_W'(thr_ff);
            step_in  = '0;
            state_in = (CMP_W'(level_ff) > CMP_W'(thr_ff)) ? ST_SCALE : ST_DONE;
         end
         ST_SCALE: begin
            // numerator = |x|*thr + level/2; its top part is already below level
            if (step_ff == CW'(1))
               acc_in = ACC_W'(prod_ff) + ACC_W'(level_ff >> 1);
            if (step_ff == CW'(2)) begin
               rem_in   = RW'(acc_ff[NW-1:SB]);
               quo_in   = acc_ff[SB-1:0];
               step_in  = '0;
               state_in = ST_DIV;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? RW'(div_diff) : RW'(div_t);
            quo_in = {quo_ff[SB-2:0], div_ge};
            if (step_ff == CW'(SB - 1)) begin
               step_in  = '0;
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = red_ff ? (x_ff[SB-1] ? SB'(-quo_ff) : quo_ff) : x_ff;
               rsp_red_in    = red_ff;
               rsp_last_in   = last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         env_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         env_ff       <= env_in;
      end
      x_ff          <= x_in;
      last_ff       <= last_in;
      det_ff        <= det_in;
      coef_ff       <= coef_in;
      prod_ff       <= mul_p;
      acc_ff        <= acc_in;
      level_ff      <= level_in;
      red_ff        <= red_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_red_ff    <= rsp_red_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.sample_out     = rsp_sample_ff;
   assign rsp_ch.reducing       = rsp_red_ff;
   assign rsp_ch.block_last_out = rsp_last_ff;

   `DEESS_ASSERT_NOW(a_div_only_when_reducing, clock, reset, state_ff == ST_DIV, red_ff)
   `DEESS_ASSERT_NOW(a_div_rem_below_level, clock, reset, state_ff == ST_DIV, rem_ff < level_ff)
   `DEESS_ASSERT_NEXT(a_done_delivers, clock, reset, state_ff == ST_DONE && rsp_ch.ready, rsp_valid_ff && state_ff == ST_IDLE)

endmodule
